// ===== rtl/core/kms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_pkg
// Shared constants, types and helpers for the key matrix scan debounce block.
// ----------------------------------------------------------------------------
package kms_pkg;

   localparam int ROWS    = 8;
   localparam int COLS    = 16;
   localparam int ROW_W   = 3;
   localparam int BITS_W  = 16;
   localparam int CFG_W   = 8;
   localparam int COUNT_W = 8;

   localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SWEEP_W = $clog2(ROWS + 1);
   localparam int TOTAL_W = $clog2(ROWS * BITS_W + 1);

   localparam logic [CFG_W-1:0]  RESET_SETTLE = CFG_W'(5);
   localparam logic [BITS_W-1:0] COL_MASK     = BITS_W'((33'd1 << COLS) - 33'd1);
   localparam int                COUNT_MAX    = (1 << COUNT_W) - 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [BITS_W-1:0]  stable_row;
      logic               settled;
      logic               committed;
      logic [COUNT_W-1:0] key_count;
   } result_type;

   typedef struct packed {
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      logic [BITS_W-1:0] wr_data;
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [TOTAL_W-1:0] popcount(input logic [BITS_W-1:0] v);
      logic [TOTAL_W-1:0] n;
      n = '0;
      for (int i = 0; i < BITS_W; i++) begin
         n = n + TOTAL_W'(v[i]);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kms_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module kms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/kms_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kms_ctrl
// Sequencer: read-compare-write of the raw row, settle counter, commit sweep.
// ----------------------------------------------------------------------------
module kms_ctrl
   import kms_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ROW_W-1:0]   req_row,
   input  wire logic [BITS_W-1:0]  req_bits,
   input  wire logic               req_last,
   input  wire logic [CFG_W-1:0]   debounce,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output result_type              res,
   output mem_req_type             raw_req,
   input  wire logic [BITS_W-1:0]  raw_rd_data,
   output mem_req_type             stb_req,
   input  wire logic [BITS_W-1:0]  stb_rd_data
);

   state_type           state_ff, state_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic                last_ff, last_in;
   logic [CFG_W-1:0]    settle_ff, settle_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [SWEEP_W-1:0]  sweep_ff, sweep_in;
   logic [TOTAL_W-1:0]  acc_ff, acc_in;
   logic [BITS_W-1:0]   stable_out_ff, stable_out_in;
   logic                committed_ff, committed_in;
   logic [ROWS-1:0]     raw_vld_ff, raw_vld_in;
   logic                stb_vld_ff, stb_vld_in;

   logic                in_range;
   logic [ROW_AW-1:0]   row_addr;
   logic [BITS_W-1:0]   raw_cur;
   logic [BITS_W-1:0]   stb_cur;
   logic [CFG_W-1:0]    settle_mid;
   logic [CFG_W-1:0]    settle_dec;
   logic [SWEEP_W-1:0]  sweep_prev;
   logic [ROW_AW-1:0]   sweep_prev_addr;
   logic [BITS_W-1:0]   sweep_data;
   logic [TOTAL_W-1:0]  sweep_sum;

   assign in_range        = (32'(row_ff) < ROWS);
   assign row_addr        = ROW_AW'(row_ff);
   assign raw_cur         = raw_vld_ff[row_addr] ? raw_rd_data : '0;
   assign stb_cur         = stb_vld_ff ? stb_rd_data : '0;
   assign settle_dec      = settle_mid - CFG_W'(1);
   assign sweep_prev      = sweep_ff - SWEEP_W'(1);
   assign sweep_prev_addr = ROW_AW'(sweep_prev);
   assign sweep_data      = raw_vld_ff[sweep_prev_addr] ? raw_rd_data : '0;
   assign sweep_sum       = acc_ff + popcount(sweep_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         settle_ff  <= RESET_SETTLE;
         total_ff   <= '0;
         raw_vld_ff <= '0;
         stb_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         settle_ff  <= settle_in;
         total_ff   <= total_in;
         raw_vld_ff <= raw_vld_in;
         stb_vld_ff <= stb_vld_in;
      end
      row_ff        <= row_in;
      bits_ff       <= bits_in;
      last_ff       <= last_in;
      sweep_ff      <= sweep_in;
      acc_ff        <= acc_in;
      stable_out_ff <= stable_out_in;
      committed_ff  <= committed_in;
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      bits_in       = bits_ff;
      last_in       = last_ff;
      settle_in     = settle_ff;
      total_in      = total_ff;
      sweep_in      = sweep_ff;
      acc_in        = acc_ff;
      stable_out_in = stable_out_ff;
      committed_in  = committed_ff;
      raw_vld_in    = raw_vld_ff;
      stb_vld_in    = stb_vld_ff;
      settle_mid    = settle_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      raw_req       = '0;
      stb_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Launch reads of both stores at the incoming row
            req_ready       = 1'b1;
            raw_req.rd_addr = ROW_AW'(req_row);
            stb_req.rd_addr = ROW_AW'(req_row);
            if (req_valid) begin
               raw_req.rd_en = 1'b1;
               stb_req.rd_en = 1'b1;
               row_in        = req_row;
               bits_in       = req_bits & COL_MASK;
               last_in       = req_last;
               state_in      = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (in_range && (raw_cur != bits_ff)) begin
               raw_req.wr_en        = 1'b1;
               raw_req.wr_addr      = row_addr;
               raw_req.wr_data      = bits_ff;
               raw_vld_in[row_addr] = 1'b1;
               settle_mid           = (debounce == '0) ? CFG_W'(1) : debounce;
            end
            settle_in    = settle_mid;
            committed_in = 1'b0;
            if (last_ff && (settle_mid != '0)) begin
               settle_in = settle_dec;
               if (settle_dec == '0) begin
                  committed_in = 1'b1;
               end
            end
            // After a commit the stable row equals the fresh raw row
            if (!in_range) begin
               stable_out_in = '0;
            end else if (committed_in) begin
               stable_out_in = bits_ff;
            end else begin
               stable_out_in = stb_cur;
            end
            sweep_in = '0;
            acc_in   = '0;
            state_in = committed_in ? ST_SWEEP : ST_RESP;
         end

         ST_SWEEP: begin
            // Read raw entry i while writing raw entry i-1 into the stable store
            raw_req.rd_addr = ROW_AW'(sweep_ff);
            raw_req.rd_en   = (32'(sweep_ff) < ROWS);
            if (sweep_ff != '0) begin
               stb_req.wr_en   = 1'b1;
               stb_req.wr_addr = sweep_prev_addr;
               stb_req.wr_data = sweep_data;
               acc_in          = sweep_sum;
            end
            sweep_in = sweep_ff + SWEEP_W'(1);
            if (sweep_ff == SWEEP_W'(ROWS)) begin
               stb_vld_in = 1'b1;
               total_in   = (32'(sweep_sum) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                        : COUNT_W'(sweep_sum);
               state_in   = ST_RESP;
            end
         end

         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res.stable_row = stable_out_ff;
      res.settled    = (settle_ff == '0);
      res.committed  = committed_ff;
      res.key_count  = total_ff;
   end

endmodule
`default_nettype wire

// ===== rtl/core/key_matrix_scan_debounce_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an accepted row goes through ST_CHECK and ST_RESP into the result
//   register, with the commit sweep (ST_SWEEP) in between when the row ends a
//   pass and the settle counter expires. A new row is taken only in ST_IDLE;
//   the sweep walks the raw store one entry per cycle through its single read port.
// Reset: synchronous; counter and debounce register return to 5, key count
//   to zero; per-entry valid flags on the raw store and one flag on the stable
//   store make both read as zero, no clear pass.
// ----------------------------------------------------------------------------
// key_matrix_scan_debounce_top
// Keyboard matrix scan with one shared settle counter and a stable matrix.
// ----------------------------------------------------------------------------
module key_matrix_scan_debounce_top
   import kms_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // input stream
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,   // [15:0] pressed_bits
   input  wire logic [7:0]        req_tuser,   // [2:0] row, rest zero
   input  wire logic              req_tlast,   // last_row
   // result stream
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [23:0]       rsp_tdata,   // [15:0] stable_row, [23:16] key_count
   output logic      [7:0]        rsp_tuser,   // [0] settled, [1] committed, rest zero
   // debounce register write
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data     // [7:0] debounce_scans
);

   logic [CFG_W-1:0]  debounce_ff, debounce_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              res_valid;
   logic              res_ready;
   result_type        res;
   mem_req_type       raw_req;
   mem_req_type       stb_req;
   logic [BITS_W-1:0] raw_rd_data;
   logic [BITS_W-1:0] stb_rd_data;

   // Take register writes at any time; the new value applies at the next reload
   assign csr_ready   = 1'b1;
   assign debounce_in = (csr_valid && csr_ready) ? csr_data : debounce_ff;

   // Output register: load when empty or being drained this cycle
   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (res_valid && res_ready) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_in       = (res_valid && res_ready) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= RESET_SETTLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.key_count, rsp_ff.stable_row};
   assign rsp_tuser  = {6'b0, rsp_ff.committed, rsp_ff.settled};

   kms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_row     (req_tuser[ROW_W-1:0]),
      .req_bits    (req_tdata),
      .req_last    (req_tlast),
      .debounce    (debounce_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .raw_req     (raw_req),
      .raw_rd_data (raw_rd_data),
      .stb_req     (stb_req),
      .stb_rd_data (stb_rd_data)
   );

   // Raw sample store: one entry per row
   kms_ram #(
      .WIDTH (BITS_W),
      .DEPTH (ROWS),
      .AW    (ROW_AW)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_req.wr_en),
      .wr_addr (raw_req.wr_addr),
      .wr_data (raw_req.wr_data),
      .rd_en   (raw_req.rd_en),
      .rd_addr (raw_req.rd_addr),
      .rd_data (raw_rd_data)
   );

   // Stable matrix store: filled by the commit sweep
   kms_ram #(
      .WIDTH (BITS_W),
      .DEPTH (ROWS),
      .AW    (ROW_AW)
   ) u_stable_ram (
      .clock   (clock),
      .wr_en   (stb_req.wr_en),
      .wr_addr (stb_req.wr_addr),
      .wr_data (stb_req.wr_data),
      .rd_en   (stb_req.rd_en),
      .rd_addr (stb_req.rd_addr),
      .rd_data (stb_rd_data)
   );

endmodule
`default_nettype wire
